/* src/wds_pkg.sv */
`timescale 1ns / 1ps

package wds_pkg;

  // Default sizing
  localparam int DEF_MAX_SIDES   = 64;
  localparam int DEF_WEIGHT_BITS = 16;
  localparam int DEF_RANDOM_BITS = 32;

  // Fixed width of the side field
  localparam int SIDE_W = 7;

  // Item opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_ROLL = 1'b1;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_SCAN,
    ST_PUSH
  } wds_state_t;

endpackage

/* src/weighted_die_sampler.sv */
`timescale 1ns / 1ps

// Weighted die sampler: load items (op 0) append a weight to the side table and
// add it to the running sum; first restarts the table, and loads into a full
// table are dropped. A roll item (op 1) returns the first side k (from 1) whose
// cumulative weight p satisfies random * sum < p * 2^RANDOM_BITS, the side
// count with fell_through set when none does, and side 0 for an empty table.
// A load gives no result. For a roll, the product random * sum is first built
// by one shift-add adder, one sum bit per cycle, then the cumulative weights
// are scanned one table entry per cycle (k entries, k <= side count) from the
// single read port of the weight memory, and the result goes out through a
// one-item output register. in_ready is high only between items.
module weighted_die_sampler
  import wds_pkg::*;
#(
  parameter int MAX_SIDES   = DEF_MAX_SIDES,
  parameter int WEIGHT_BITS = DEF_WEIGHT_BITS,
  parameter int RANDOM_BITS = DEF_RANDOM_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_op,
  input  logic                   in_first,
  input  logic [WEIGHT_BITS-1:0] in_weight,
  input  logic [RANDOM_BITS-1:0] in_random,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SIDE_W-1:0]      out_side,
  output logic                   out_fell_through
);

  localparam int IDX_W  = $clog2(MAX_SIDES);
  localparam int CNT_W  = $clog2(MAX_SIDES + 1);
  localparam int SUM_W  = WEIGHT_BITS + IDX_W;
  localparam int PROD_W = RANDOM_BITS + SUM_W;
  localparam int MC_W   = $clog2(SUM_W);

  wds_state_t state_r, state_nxt;

  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [SUM_W-1:0]       sum_r, sum_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic [SUM_W-1:0]       prefix_r, prefix_nxt;
  logic [PROD_W-1:0]      acc_r, acc_nxt;
  logic [SUM_W-1:0]       msh_r, msh_nxt;
  logic [MC_W-1:0]        mcnt_r, mcnt_nxt;
  logic [RANDOM_BITS-1:0] rnd_r, rnd_nxt;
  logic [CNT_W-1:0]       res_side_r, res_side_nxt;
  logic                   res_fell_r, res_fell_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [SIDE_W-1:0]      out_side_r, out_side_nxt;
  logic                   out_fell_r, out_fell_nxt;

  // Weight memory, one write and one registered read port
  logic [WEIGHT_BITS-1:0] mem [MAX_SIDES];
  logic [WEIGHT_BITS-1:0] rd_data_r;
  logic                   wr_en;
  logic [IDX_W-1:0]       wr_addr;

  // Scan datapath
  logic [SUM_W-1:0] prefix_new;
  logic [CNT_W-1:0] side_next;
  logic [SUM_W-1:0] prod_hi;

  assign in_ready         = (state_r == ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_side         = out_side_r;
  assign out_fell_through = out_fell_r;

  // Upper part of r * sum: below p * 2^RANDOM_BITS exactly when below p
  assign prod_hi    = acc_r[PROD_W-1 -: SUM_W];
  assign prefix_new = prefix_r + SUM_W'(rd_data_r);
  assign side_next  = CNT_W'(idx_r) + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_weight;
    end
    rd_data_r <= mem[idx_nxt];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    prefix_r   <= prefix_nxt;
    acc_r      <= acc_nxt;
    msh_r      <= msh_nxt;
    mcnt_r     <= mcnt_nxt;
    rnd_r      <= rnd_nxt;
    res_side_r <= res_side_nxt;
    res_fell_r <= res_fell_nxt;
    out_side_r <= out_side_nxt;
    out_fell_r <= out_fell_nxt;
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    sum_nxt       = sum_r;
    idx_nxt       = idx_r;
    prefix_nxt    = prefix_r;
    acc_nxt       = acc_r;
    msh_nxt       = msh_r;
    mcnt_nxt      = mcnt_r;
    rnd_nxt       = rnd_r;
    res_side_nxt  = res_side_r;
    res_fell_nxt  = res_fell_r;
    out_valid_nxt = out_valid_r;
    out_side_nxt  = out_side_r;
    out_fell_nxt  = out_fell_r;
    wr_en         = 1'b0;
    wr_addr       = '0;

    // result taken downstream
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_op == OP_LOAD) begin
            if (in_first) begin
              wr_en     = 1'b1;
              wr_addr   = '0;
              count_nxt = CNT_W'(1);
              sum_nxt   = SUM_W'(in_weight);
            end else if (count_r < CNT_W'(MAX_SIDES)) begin
              wr_en     = 1'b1;
              wr_addr   = count_r[IDX_W-1:0];
              count_nxt = count_r + CNT_W'(1);
              sum_nxt   = sum_r + SUM_W'(in_weight);
            end
          end else begin
            rnd_nxt    = in_random;
            idx_nxt    = '0;
            prefix_nxt = '0;
            if (count_r == '0) begin
              // empty table
              res_side_nxt = '0;
              res_fell_nxt = 1'b1;
              state_nxt    = ST_PUSH;
            end else begin
              acc_nxt   = '0;
              msh_nxt   = sum_r;
              mcnt_nxt  = MC_W'(SUM_W - 1);
              state_nxt = ST_MUL;
            end
          end
        end
      end

      ST_MUL: begin
        // shift-add, sum bits MSB first
        acc_nxt = {acc_r[PROD_W-2:0], 1'b0} +
                  (msh_r[SUM_W-1] ? PROD_W'(rnd_r) : PROD_W'(0));
        msh_nxt = {msh_r[SUM_W-2:0], 1'b0};
        if (mcnt_r == '0) begin
          state_nxt = ST_SCAN;
        end else begin
          mcnt_nxt = mcnt_r - MC_W'(1);
        end
      end

      ST_SCAN: begin
        prefix_nxt = prefix_new;
        if (prod_hi < prefix_new) begin
          res_side_nxt = side_next;
          res_fell_nxt = 1'b0;
          state_nxt    = ST_PUSH;
        end else if (side_next == count_r) begin
          res_side_nxt = count_r;
          res_fell_nxt = 1'b1;
          state_nxt    = ST_PUSH;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end

      ST_PUSH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_side_nxt  = SIDE_W'(res_side_r);
          out_fell_nxt  = res_fell_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  // side count never passes the table size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_SIDES))
    else $error("side count beyond table size");

  // scan stays inside the loaded sides
  a_scan_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (CNT_W'(idx_r) < count_r))
    else $error("scan index past side count");

  // an accepted roll always starts work
  a_roll_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_op == OP_ROLL)) |=> (state_r != ST_IDLE))
    else $error("roll item accepted but sequencer idle");

  // a new result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> out_valid_r)
    else $error("pending result dropped");
`endif

endmodule
